// ----- hw/rtl/four_digit_seven_segment_scan_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the four-digit seven-segment scan block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCAN_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define SDSCAN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SDSCAN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define SDSCAN_ASSERT(lbl, prop, msg)
`define SDSCAN_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- hw/rtl/sdscan_pkg.sv -----
// ----------------------------------------------------------------------------
// sdscan_pkg
// Types, constants and the segment decoder shared by the scan block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdscan_pkg;

  localparam int unsigned NumW       = 14;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned SegW       = 7;
  localparam int unsigned PosW       = 2;
  localparam int unsigned DigitCount = 4;

  localparam logic [NumW-1:0] MaxNumber = 14'd9999;
  localparam logic [PosW-1:0] LastPos   = 2'd3;

  // Place weights, thousands first.
  localparam int unsigned PlaceWeight [DigitCount] = '{1000, 100, 10, 1};

  // Beat handed from one digit cell to the next.
  typedef struct packed {
    logic [NumW-1:0]                    rem;
    logic [DigitCount-1:0][DigitW-1:0]  digits;
  } beat_t;

  // Active-low patterns, bit0 = segment a.
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h40;
      4'd1:    seg = 7'h79;
      4'd2:    seg = 7'h24;
      4'd3:    seg = 7'h30;
      4'd4:    seg = 7'h19;
      4'd5:    seg = 7'h12;
      4'd6:    seg = 7'h02;
      4'd7:    seg = 7'h78;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h10;
      default: seg = 7'h7F;
    endcase
    return seg;
  endfunction

endpackage

// ----- hw/rtl/four_digit_seven_segment_scan.sv -----
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan
// Number to four active-low seven-segment digit beats, thousands first.
// ----------------------------------------------------------------------------
// Each accepted number (values above 9999 show as 9999) yields four output
// beats, thousands, hundreds, tens, ones, each with its position, segment
// pattern, point level and a last flag on the ones digit. The number walks a
// chain of four digit cells, one per place weight, one cell per cycle while
// the next stage is ready, and then loads the output shifter, which registers
// the four segment patterns. The output shifter sends one beat per cycle
// while out_ready_i is high; the chain keeps taking new numbers while the
// shifter is still sending, until it holds four.
`timescale 1ns / 1ps

module four_digit_seven_segment_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sdscan_pkg::NumW-1:0]    number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdscan_pkg::PosW-1:0]    digit_position_o,
  output logic [sdscan_pkg::SegW-1:0]    segments_o,
  output logic                           point_level_o,
  output logic                           last_o
);
  import sdscan_pkg::*;

  beat_t beat [DigitCount+1];
  logic  vld  [DigitCount+1];
  logic  rdy  [DigitCount+1];

  always_comb begin
    beat[0].rem    = (number_i > MaxNumber) ? MaxNumber : number_i;
    beat[0].digits = '0;
  end

  assign vld[0]     = in_valid_i;
  assign in_ready_o = rdy[0];

  for (genvar i = 0; i < DigitCount; i++) begin : g_cell
    sdscan_cell #(
      .WEIGHT (PlaceWeight[i]),
      .SLOT   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (vld[i]),
      .up_ready_o (rdy[i]),
      .up_beat_i  (beat[i]),
      .dn_valid_o (vld[i+1]),
      .dn_ready_i (rdy[i+1]),
      .dn_beat_o  (beat[i+1])
    );
  end

  sdscan_ser u_ser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (vld[DigitCount]),
    .in_ready_o       (rdy[DigitCount]),
    .digits_i         (beat[DigitCount].digits),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .point_level_o    (point_level_o),
    .last_o           (last_o)
  );

endmodule

// ----- hw/rtl/sdscan_cell.sv -----
// ----------------------------------------------------------------------------
// sdscan_cell
// One stage of the digit chain: takes the remainder, pulls out the digit for
// its place weight and hands the reduced remainder to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_digit_seven_segment_scan_macros.svh"

module sdscan_cell #(
  parameter int unsigned WEIGHT = 1000,
  parameter int unsigned SLOT   = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  sdscan_pkg::beat_t up_beat_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output sdscan_pkg::beat_t dn_beat_o
);
  import sdscan_pkg::*;

  logic            valid_q;
  beat_t           beat_q;
  logic [8:0]      ge;
  logic [DigitW-1:0] digit;
  logic [NumW-1:0] sub;

  // Remainder is below ten times the weight, so the digit is the number of
  // multiples it reaches; all nine compares run side by side.
  always_comb begin
    sub   = '0;
    digit = '0;
    for (int k = 1; k <= 9; k++) begin
      ge[k-1] = beat_q.rem >= NumW'(k * WEIGHT);
      if (ge[k-1]) begin
        sub = NumW'(k * WEIGHT);
      end
      digit = digit + DigitW'(ge[k-1]);
    end
  end

  always_comb begin
    dn_beat_o              = beat_q;
    dn_beat_o.rem          = beat_q.rem - sub;
    dn_beat_o.digits[SLOT] = digit;
  end

  assign dn_valid_o = valid_q;
  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      beat_q <= up_beat_i;
    end
  end

  `SDSCAN_ASSERT(a_cell_digit_dec, !valid_q || digit <= DigitW'(9), "cell digit above nine")

endmodule

// ----- hw/rtl/sdscan_ser.sv -----
// ----------------------------------------------------------------------------
// sdscan_ser
// Decodes the four digits to segment patterns and shifts them out one beat
// per digit, thousands first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_digit_seven_segment_scan_macros.svh"

module sdscan_ser (
  input  logic                                                       clk_i,
  input  logic                                                       rst_ni,
  input  logic                                                       in_valid_i,
  output logic                                                       in_ready_o,
  input  logic [sdscan_pkg::DigitCount-1:0][sdscan_pkg::DigitW-1:0]  digits_i,
  output logic                                                       out_valid_o,
  input  logic                                                       out_ready_i,
  output logic [sdscan_pkg::PosW-1:0]                                digit_position_o,
  output logic [sdscan_pkg::SegW-1:0]                                segments_o,
  output logic                                                       point_level_o,
  output logic                                                       last_o
);
  import sdscan_pkg::*;

  logic                             busy_q, busy_d;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic [DigitCount-1:0][SegW-1:0]  seg_q, seg_d;
  logic                             out_fire, load, at_last;

  assign at_last    = pos_q == LastPos;
  assign out_fire   = busy_q && out_ready_i;
  assign in_ready_o = !busy_q || (out_fire && at_last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    seg_d  = seg_q;
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
      for (int i = 0; i < DigitCount; i++) begin
        seg_d[i] = seg_decode(digits_i[i]);
      end
    end else if (out_fire) begin
      pos_d = pos_q + PosW'(1);
      for (int i = 0; i < DigitCount - 1; i++) begin
        seg_d[i] = seg_q[i+1];
      end
      seg_d[DigitCount-1] = '0;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign out_valid_o      = busy_q;
  assign digit_position_o = pos_q;
  assign segments_o       = seg_q[0];
  assign point_level_o    = !at_last;
  assign last_o           = at_last;

  `SDSCAN_ASSERT_NEXT(a_ser_load, load, busy_q && pos_q == '0, "load did not restart scan")
  `SDSCAN_ASSERT_NEXT(a_ser_step, out_fire && !at_last,
                      busy_q && pos_q == $past(pos_q) + PosW'(1), "scan skipped a digit")
  `SDSCAN_ASSERT_NEXT(a_ser_done, out_fire && at_last && !in_valid_i, !busy_q,
                      "scan ran past the ones digit")

endmodule
